[design/spi_master_fifo_cs_framer_unit_assert.svh]
// Assertion helpers for the SPI framer block.
`ifndef SPI_MASTER_FIFO_CS_FRAMER_UNIT_ASSERT_SVH
`define SPI_MASTER_FIFO_CS_FRAMER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define SMCF_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is high.
`define SMCF_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

[design/smcf_pkg.sv]
`timescale 1ns / 1ps

package smcf_pkg;

   localparam int TX_DEPTH = 16;
   localparam int RX_DEPTH = 16;
   localparam int TX_PTR_W = $clog2(TX_DEPTH);
   localparam int RX_PTR_W = $clog2(RX_DEPTH);
   localparam int WAIT_W   = 5;
   localparam int BYTE_W   = 8;
   localparam int ACT_W    = 3;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 8;

   // action codes
   localparam logic [ACT_W-1:0] ACT_PUSH     = 3'd0;
   localparam logic [ACT_W-1:0] ACT_PUSH_ARM = 3'd1;
   localparam logic [ACT_W-1:0] ACT_DONE     = 3'd2;
   localparam logic [ACT_W-1:0] ACT_POP      = 3'd3;
   localparam logic [ACT_W-1:0] ACT_CLEAR    = 3'd4;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_CS_ACTIVE_LOW = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_LENGTH  = 1'd1;

   localparam logic [BYTE_W-1:0] FRAME_LENGTH_RESET = 8'd1;

   // result of one transaction, held between accept and the output register
   typedef struct packed {
      logic              accepted;
      logic              send_valid;
      logic              send_fwd;
      logic [BYTE_W-1:0] send_data;
      logic              cs_level;
      logic              rx_valid;
      logic [WAIT_W-1:0] rx_waiting;
      logic [WAIT_W-1:0] tx_waiting;
      logic              rx_full;
   } pend_type;

   typedef struct packed {
      logic              accepted;
      logic              send_valid;
      logic [BYTE_W-1:0] send_byte;
      logic              cs_level;
      logic              rx_valid;
      logic [BYTE_W-1:0] rx_byte;
      logic [WAIT_W-1:0] rx_waiting;
      logic [WAIT_W-1:0] tx_waiting;
      logic              rx_full;
   } rsp_type;

endpackage

[design/smcf_channel_if.sv]
`timescale 1ns / 1ps

interface smcf_req_if;
   logic                            valid;
   logic                            ready;
   logic [smcf_pkg::ACT_W-1:0]      action;
   logic [smcf_pkg::BYTE_W-1:0]     data;

   modport source (output valid, output action, output data, input ready);
   modport sink   (input valid, input action, input data, output ready);
endinterface

interface smcf_rsp_if;
   logic                            valid;
   logic                            ready;
   logic                            accepted;
   logic                            send_valid;
   logic [smcf_pkg::BYTE_W-1:0]     send_byte;
   logic                            cs_level;
   logic                            rx_valid;
   logic [smcf_pkg::BYTE_W-1:0]     rx_byte;
   logic [smcf_pkg::WAIT_W-1:0]     rx_waiting;
   logic [smcf_pkg::WAIT_W-1:0]     tx_waiting;
   logic                            rx_full;

   modport source (output valid, output accepted, output send_valid, output send_byte,
                   output cs_level, output rx_valid, output rx_byte, output rx_waiting,
                   output tx_waiting, output rx_full, input ready);
   modport sink   (input valid, input accepted, input send_valid, input send_byte,
                   input cs_level, input rx_valid, input rx_byte, input rx_waiting,
                   input tx_waiting, input rx_full, output ready);
endinterface

[design/spi_master_fifo_cs_framer_unit.sv]
// A result moves from the pending register to the output register and can wait in either.
// Throughput: one transaction per cycle while the result side keeps taking.
// Each ring buffer memory has one synchronous read, registered at accept.
// Reset (synchronous, active high) clears pointers, flags, frame count, configuration and valid bits;
// ring buffer contents stay undefined until written, so no clearing pass runs.
`timescale 1ns / 1ps
`include "spi_master_fifo_cs_framer_unit_assert.svh"

module spi_master_fifo_cs_framer_unit (
   input  logic                                 clock,
   input  logic                                 reset,
   smcf_req_if.sink                             req,
   smcf_rsp_if.source                           rsp,
   input  logic                                 csr_write_enable,
   input  logic [smcf_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [smcf_pkg::CSR_DATA_W-1:0]      csr_write_data
);

   localparam int TXP = smcf_pkg::TX_PTR_W;
   localparam int RXP = smcf_pkg::RX_PTR_W;
   localparam int BW  = smcf_pkg::BYTE_W;
   localparam int WW  = smcf_pkg::WAIT_W;

   localparam logic [TXP-1:0] TX_LAST = TXP'(smcf_pkg::TX_DEPTH - 1);
   localparam logic [RXP-1:0] RX_LAST = RXP'(smcf_pkg::RX_DEPTH - 1);
   localparam logic [TXP:0]   TX_SPAN = (TXP+1)'(smcf_pkg::TX_DEPTH);
   localparam logic [RXP:0]   RX_SPAN = (RXP+1)'(smcf_pkg::RX_DEPTH);

   // ring buffer memories
   logic [BW-1:0] tx_mem [smcf_pkg::TX_DEPTH];
   logic [BW-1:0] rx_mem [smcf_pkg::RX_DEPTH];

   // configuration
   logic          cs_active_low_ff;
   logic [BW-1:0] frame_length_ff;

   // ring and frame state
   logic [TXP-1:0] tx_wp_ff, tx_wp_in, tx_rp_ff, tx_rp_in;
   logic [RXP-1:0] rx_wp_ff, rx_wp_in, rx_rp_ff, rx_rp_in;
   logic           tx_idle_ff, tx_idle_in;
   logic           rx_ovr_ff, rx_ovr_in;
   logic           armed_ff, armed_in;
   logic           cs_ff, cs_in;
   logic [BW-1:0]  fc_ff, fc_in, fc_mid;

   // memory access
   logic           tx_we, rx_we;
   logic [TXP-1:0] tx_raddr;
   logic [RXP-1:0] rx_raddr;
   logic [BW-1:0]  tx_rdata_ff, rx_rdata_ff;

   // pending result and output register
   logic                 pend_valid_ff, pend_valid_in;
   smcf_pkg::pend_type   pend_ff, pend_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   smcf_pkg::rsp_type    out_ff, out_in;

   logic           accept, move, tx_full, frame_end;
   logic [TXP-1:0] tx_rp_next;
   logic [TXP:0]   tx_diff;
   logic [RXP:0]   rx_diff;

   // Hand the pending result on when the output register is empty or being taken;
   // accept a new transaction in that same cycle.
   assign move       = pend_valid_ff && (!rsp_valid_ff || rsp.ready);
   assign req.ready  = !pend_valid_ff || move;
   assign accept     = req.valid && req.ready;

   assign tx_full    = (tx_wp_ff == tx_rp_ff) && !tx_idle_ff;
   assign frame_end  = (fc_ff == frame_length_ff);
   assign tx_rp_next = (tx_rp_ff == TX_LAST) ? '0 : tx_rp_ff + 1'b1;

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         cs_active_low_ff <= 1'b0;
         frame_length_ff  <= smcf_pkg::FRAME_LENGTH_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            smcf_pkg::CSR_CS_ACTIVE_LOW: cs_active_low_ff <= csr_write_data[0];
            smcf_pkg::CSR_FRAME_LENGTH:  frame_length_ff  <= csr_write_data[BW-1:0];
            default: ;
         endcase
      end
   end

   // Next state of the rings and the frame, decoded from the accepted transaction
   always_comb begin
      tx_wp_in   = tx_wp_ff;
      tx_rp_in   = tx_rp_ff;
      rx_wp_in   = rx_wp_ff;
      rx_rp_in   = rx_rp_ff;
      tx_idle_in = tx_idle_ff;
      rx_ovr_in  = rx_ovr_ff;
      armed_in   = armed_ff;
      cs_in      = cs_ff;
      fc_in      = fc_ff;
      fc_mid     = fc_ff;
      tx_we      = 1'b0;
      rx_we      = 1'b0;
      tx_raddr   = tx_rp_next;
      rx_raddr   = rx_rp_ff;
      pend_in    = '0;

      if (accept) begin
         case (req.action)
            smcf_pkg::ACT_PUSH, smcf_pkg::ACT_PUSH_ARM: begin
               // arm even when the push is refused
               if (req.action == smcf_pkg::ACT_PUSH_ARM) begin
                  armed_in = 1'b1;
               end
               if (!tx_full) begin
                  tx_we            = 1'b1;
                  tx_wp_in         = (tx_wp_ff == TX_LAST) ? '0 : tx_wp_ff + 1'b1;
                  pend_in.accepted = 1'b1;
                  if (tx_idle_ff) begin
                     // the ring was empty: start this byte at once, forward it
                     cs_in              = 1'b1;
                     fc_in              = fc_ff + 1'b1;
                     tx_idle_in         = 1'b0;
                     pend_in.send_valid = 1'b1;
                     pend_in.send_fwd   = 1'b1;
                     pend_in.send_data  = req.data;
                  end
               end
            end
            smcf_pkg::ACT_DONE: begin
               if (armed_ff) begin
                  if (!rx_ovr_ff) begin
                     rx_we    = 1'b1;
                     rx_wp_in = (rx_wp_ff == RX_LAST) ? '0 : rx_wp_ff + 1'b1;
                     if (rx_wp_in == rx_rp_ff) begin
                        rx_ovr_in = 1'b1;
                     end
                     if (frame_end) begin
                        armed_in = 1'b0;
                     end
                  end else begin
                     // capture into a full ring: drop the byte and clear the ring
                     rx_wp_in  = '0;
                     rx_rp_in  = '0;
                     rx_ovr_in = 1'b0;
                  end
               end
               if (frame_end) begin
                  cs_in  = 1'b0;
                  fc_mid = '0;
               end
               fc_in = fc_mid;
               if (!tx_idle_ff) begin
                  tx_rp_in = tx_rp_next;
                  if (tx_wp_ff == tx_rp_next) begin
                     tx_idle_in = 1'b1;
                  end else begin
                     // next queued byte comes from the read port
                     cs_in              = 1'b1;
                     fc_in              = fc_mid + 1'b1;
                     pend_in.send_valid = 1'b1;
                  end
               end
            end
            smcf_pkg::ACT_POP: begin
               if ((rx_rp_ff != rx_wp_ff) || rx_ovr_ff) begin
                  pend_in.rx_valid = 1'b1;
                  rx_rp_in  = (rx_rp_ff == RX_LAST) ? '0 : rx_rp_ff + 1'b1;
                  rx_ovr_in = 1'b0;
               end
            end
            smcf_pkg::ACT_CLEAR: begin
               rx_wp_in  = '0;
               rx_rp_in  = '0;
               rx_ovr_in = 1'b0;
            end
            default: ;
         endcase
      end

      // status after this transaction
      tx_diff = (tx_wp_in >= tx_rp_in) ? {1'b0, tx_wp_in} - {1'b0, tx_rp_in}
                                       : {1'b0, tx_wp_in} + TX_SPAN - {1'b0, tx_rp_in};
      rx_diff = (rx_wp_in >= rx_rp_in) ? {1'b0, rx_wp_in} - {1'b0, rx_rp_in}
                                       : {1'b0, rx_wp_in} + RX_SPAN - {1'b0, rx_rp_in};
      pend_in.cs_level   = cs_in ^ cs_active_low_ff;
      pend_in.rx_full    = rx_ovr_in;
      pend_in.rx_waiting = rx_ovr_in ? WW'(RX_SPAN) : WW'(rx_diff);
      pend_in.tx_waiting = ((tx_wp_in == tx_rp_in) && !tx_idle_in) ? WW'(TX_SPAN)
                                                                   : WW'(tx_diff);
   end

   // Transmit ring: write the pushed byte, read the next byte to send
   always_ff @(posedge clock) begin
      if (tx_we) begin
         tx_mem[tx_wp_ff] <= req.data;
      end
      if (accept) begin
         tx_rdata_ff <= tx_mem[tx_raddr];
      end
   end

   // Receive ring: write the captured byte, read the byte to pop
   always_ff @(posedge clock) begin
      if (rx_we) begin
         rx_mem[rx_wp_ff] <= req.data;
      end
      if (accept) begin
         rx_rdata_ff <= rx_mem[rx_raddr];
      end
   end

   // Ring and frame state
   always_ff @(posedge clock) begin
      if (reset) begin
         tx_wp_ff   <= '0;
         tx_rp_ff   <= '0;
         rx_wp_ff   <= '0;
         rx_rp_ff   <= '0;
         tx_idle_ff <= 1'b1;
         rx_ovr_ff  <= 1'b0;
         armed_ff   <= 1'b0;
         cs_ff      <= 1'b0;
         fc_ff      <= '0;
      end else begin
         tx_wp_ff   <= tx_wp_in;
         tx_rp_ff   <= tx_rp_in;
         rx_wp_ff   <= rx_wp_in;
         rx_rp_ff   <= rx_rp_in;
         tx_idle_ff <= tx_idle_in;
         rx_ovr_ff  <= rx_ovr_in;
         armed_ff   <= armed_in;
         cs_ff      <= cs_in;
         fc_ff      <= fc_in;
      end
   end

   // Merge memory read data into the result as it moves to the output register
   always_comb begin
      out_in            = out_ff;
      rsp_valid_in      = rsp_valid_ff;
      pend_valid_in     = pend_valid_ff;
      if (move) begin
         rsp_valid_in      = 1'b1;
         pend_valid_in     = 1'b0;
         out_in.accepted   = pend_ff.accepted;
         out_in.send_valid = pend_ff.send_valid;
         out_in.send_byte  = !pend_ff.send_valid ? '0 :
                             (pend_ff.send_fwd ? pend_ff.send_data : tx_rdata_ff);
         out_in.cs_level   = pend_ff.cs_level;
         out_in.rx_valid   = pend_ff.rx_valid;
         out_in.rx_byte    = pend_ff.rx_valid ? rx_rdata_ff : '0;
         out_in.rx_waiting = pend_ff.rx_waiting;
         out_in.tx_waiting = pend_ff.tx_waiting;
         out_in.rx_full    = pend_ff.rx_full;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (accept) begin
         pend_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload: hold unless a new transaction or result arrives
   always_ff @(posedge clock) begin
      if (accept) begin
         pend_ff <= pend_in;
      end
      out_ff <= out_in;
   end

   assign rsp.valid      = rsp_valid_ff;
   assign rsp.accepted   = out_ff.accepted;
   assign rsp.send_valid = out_ff.send_valid;
   assign rsp.send_byte  = out_ff.send_byte;
   assign rsp.cs_level   = out_ff.cs_level;
   assign rsp.rx_valid   = out_ff.rx_valid;
   assign rsp.rx_byte    = out_ff.rx_byte;
   assign rsp.rx_waiting = out_ff.rx_waiting;
   assign rsp.tx_waiting = out_ff.tx_waiting;
   assign rsp.rx_full    = out_ff.rx_full;

   // an idle transmit ring is an empty one
   `SMCF_ASSERT_NOW(a_tx_idle_empty, clock, reset, tx_idle_ff, tx_wp_ff == tx_rp_ff)
   // overrun only with the pointers met
   `SMCF_ASSERT_NOW(a_rx_ovr_met, clock, reset, rx_ovr_ff, rx_wp_ff == rx_rp_ff)
   // no frame bytes counted while chip select is released
   `SMCF_ASSERT_NOW(a_fc_idle, clock, reset, !cs_ff, fc_ff == '0)
   // read data of a waiting result must survive until it moves on
   `SMCF_ASSERT_NEXT(a_rdata_hold, clock, reset, pend_valid_ff && !move,
                     $stable(tx_rdata_ff) && $stable(rx_rdata_ff))

endmodule

[sim/spi_master_fifo_cs_framer_checker.sv]
`timescale 1ns / 1ps

module spi_master_fifo_cs_framer_checker
   import smcf_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   smcf_req_if                   req,
   smcf_rsp_if                   rsp,
   input  logic                  csr_write_enable,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_write_data,
   output int                    fail_count,
   output int                    pending_count,
   output int                    checked_count,
   output int                    refused_count,
   output int                    overrun_clears
);

   // Shadow copy of the framer state and its registers
   logic [BYTE_W-1:0]   tx_mem [TX_DEPTH];
   logic [BYTE_W-1:0]   rx_mem [RX_DEPTH];
   logic [TX_PTR_W-1:0] tx_wr, tx_rd;
   logic [RX_PTR_W-1:0] rx_wr, rx_rd;
   logic                tx_idle, rx_ovr, armed, cs_on;
   logic [7:0]          frame_cnt;
   logic                cfg_cs_low;
   logic [7:0]          cfg_frame_len;

   // Status words still owed by the block, oldest first
   rsp_type owed_status [$];

   function automatic logic [TX_PTR_W-1:0] tx_adv(input logic [TX_PTR_W-1:0] p);
      return (int'(p) == TX_DEPTH - 1) ? '0 : p + 1'b1;
   endfunction

   function automatic logic [RX_PTR_W-1:0] rx_adv(input logic [RX_PTR_W-1:0] p);
      return (int'(p) == RX_DEPTH - 1) ? '0 : p + 1'b1;
   endfunction

   task automatic rx_flush();
      rx_wr  = '0;
      rx_rd  = '0;
      rx_ovr = 1'b0;
   endtask

   // Assert chip select, hand the byte at the read pointer to the shifter and count it in the frame
   task automatic launch_byte(inout rsp_type r);
      cs_on        = 1'b1;
      r.send_valid = 1'b1;
      r.send_byte  = tx_mem[tx_rd];
      frame_cnt    = frame_cnt + 8'd1;
   endtask

   task automatic advance_framer(input logic [ACT_W-1:0] act, input logic [BYTE_W-1:0] dat,
                                 output rsp_type r);
      int rx_fill;
      int tx_fill;
      r = '0;
      case (act)
         ACT_PUSH, ACT_PUSH_ARM: begin
            // arming holds even when the push is refused
            if (act == ACT_PUSH_ARM) armed = 1'b1;
            if (tx_wr == tx_rd && !tx_idle) begin
               refused_count++;
            end else begin
               tx_mem[tx_wr] = dat;
               tx_wr         = tx_adv(tx_wr);
               r.accepted    = 1'b1;
               if (tx_idle) begin
                  launch_byte(r);
                  tx_idle = 1'b0;
               end
            end
         end
         ACT_DONE: begin
            if (armed) begin
               if (!rx_ovr) begin
                  rx_mem[rx_wr] = dat;
                  rx_wr         = rx_adv(rx_wr);
                  if (rx_wr == rx_rd) rx_ovr = 1'b1;
                  if (frame_cnt == cfg_frame_len) armed = 1'b0;
               end else begin
                  // capture into a full ring drops the byte and empties the ring
                  rx_flush();
                  overrun_clears++;
               end
            end
            if (frame_cnt == cfg_frame_len) begin
               cs_on     = 1'b0;
               frame_cnt = '0;
            end
            if (!tx_idle) begin
               tx_rd = tx_adv(tx_rd);
               if (tx_wr == tx_rd) tx_idle = 1'b1;
               else                launch_byte(r);
            end
         end
         ACT_POP: begin
            if (rx_rd != rx_wr || rx_ovr) begin
               r.rx_valid = 1'b1;
               r.rx_byte  = rx_mem[rx_rd];
               rx_rd      = rx_adv(rx_rd);
               rx_ovr     = 1'b0;
            end
         end
         ACT_CLEAR: rx_flush();
         default: ;
      endcase
      rx_fill = rx_ovr ? RX_DEPTH : (int'(rx_wr) + RX_DEPTH - int'(rx_rd)) % RX_DEPTH;
      tx_fill = (tx_wr == tx_rd && !tx_idle) ? TX_DEPTH
                                             : (int'(tx_wr) + TX_DEPTH - int'(tx_rd)) % TX_DEPTH;
      r.cs_level   = cs_on ^ cfg_cs_low;
      r.rx_waiting = WAIT_W'(rx_fill);
      r.tx_waiting = WAIT_W'(tx_fill);
      r.rx_full    = rx_ovr;
   endtask

   function automatic int field_check(input string name, input logic [7:0] want,
                                      input logic [7:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected %0d, got %0d", name, want, got);
         return 1;
      end
      return 0;
   endfunction

   always @(posedge clock) begin
      rsp_type due;
      int      bad;
      if (reset) begin
         tx_wr         = '0;
         tx_rd         = '0;
         tx_idle       = 1'b1;
         rx_flush();
         armed         = 1'b0;
         frame_cnt     = '0;
         cs_on         = 1'b0;
         cfg_cs_low    = 1'b0;
         cfg_frame_len = FRAME_LENGTH_RESET;
         owed_status.delete();
      end else begin
         if (rsp.valid && rsp.ready) begin
            checked_count++;
            if (owed_status.size() == 0) begin
               $error("result transaction arrived with nothing outstanding");
               fail_count++;
            end else begin
               due = owed_status.pop_front();
               bad = 0;
               bad += field_check("accepted",   due.accepted,   rsp.accepted);
               bad += field_check("send_valid", due.send_valid, rsp.send_valid);
               bad += field_check("send_byte",  due.send_byte,  rsp.send_byte);
               bad += field_check("cs_level",   due.cs_level,   rsp.cs_level);
               bad += field_check("rx_valid",   due.rx_valid,   rsp.rx_valid);
               bad += field_check("rx_byte",    due.rx_byte,    rsp.rx_byte);
               bad += field_check("rx_waiting", due.rx_waiting, rsp.rx_waiting);
               bad += field_check("tx_waiting", due.tx_waiting, rsp.tx_waiting);
               bad += field_check("rx_full",    due.rx_full,    rsp.rx_full);
               fail_count += bad;
            end
         end
         if (csr_write_enable) begin
            case (csr_index)
               CSR_CS_ACTIVE_LOW: cfg_cs_low    = csr_write_data[0];
               CSR_FRAME_LENGTH:  cfg_frame_len = csr_write_data;
               default: ;
            endcase
         end
         if (req.valid && req.ready) begin
            advance_framer(req.action, req.data, due);
            owed_status.push_back(due);
         end
      end
      pending_count = owed_status.size();
   end

endmodule

[sim/spi_master_fifo_cs_framer_unit_test.sv]
`timescale 1ns / 1ps

module spi_master_fifo_cs_framer_unit_test;
   import smcf_pkg::*;

   // Actions the block must ignore, reporting status only
   localparam logic [ACT_W-1:0] ACT_SPARE_LO = 3'd5;
   localparam logic [ACT_W-1:0] ACT_SPARE_HI = 3'd7;

   localparam int LATENCY      = 2;        // accept to result, in cycles
   localparam int STALL_CYCLES = 120;      // long receiver hold-off
   localparam int SQUEEZE_TXNS = 40;       // back-to-back transactions during the hold-off
   localparam int LIMIT_NS     = 2_000_000;

   logic clock;
   logic reset;
   logic                  csr_write_enable;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_write_data;

   int fail_count, pending_count, checked_count, refused_count, overrun_clears;
   int txn_count;
   int setting_count;

   // Idling controls for the sender and the receiver processes
   bit send_idle_on;
   bit recv_idle_on;
   bit stall_req;

   smcf_req_if req_if ();
   smcf_rsp_if rsp_if ();

   spi_master_fifo_cs_framer_unit u_dut (
      .clock            (clock),
      .reset            (reset),
      .req              (req_if),
      .rsp              (rsp_if),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   spi_master_fifo_cs_framer_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .req              (req_if),
      .rsp              (rsp_if),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .fail_count       (fail_count),
      .pending_count    (pending_count),
      .checked_count    (checked_count),
      .refused_count    (refused_count),
      .overrun_clears   (overrun_clears)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Watchdog: end the run if the block hangs or a result never turns up
   initial begin
      #(LIMIT_NS);
      $display("Regression FAIL");
      $finish;
   end

   function automatic int draw_gap(input bit idle_on);
      return idle_on ? $urandom_range(0, 15) : 0;
   endfunction

   // Mostly random bytes, with the two extremes mixed in often
   function automatic logic [BYTE_W-1:0] rand_byte();
      case ($urandom_range(0, 7))
         0:       return 8'h00;
         1:       return 8'hFF;
         default: return BYTE_W'($urandom_range(0, 255));
      endcase
   endfunction

   // Offer one transaction after an optional gap and hold it until the block takes it.
   // Valid stays high on return, so a back-to-back transaction follows with valid never dropped.
   task automatic send_txn(input logic [ACT_W-1:0] act, input logic [BYTE_W-1:0] dat);
      int gap;
      gap = draw_gap(send_idle_on);
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid  <= 1'b1;
      req_if.action <= act;
      req_if.data   <= dat;
      do @(posedge clock); while (!req_if.ready);
      txn_count++;
   endtask

   // Drop valid and wait until every owed result has come back, then let the pipe settle.
   // Sample the count at the falling edge so the checker has finished its update.
   task automatic wait_quiet();
      req_if.valid <= 1'b0;
      @(negedge clock);
      while (pending_count != 0) @(negedge clock);
      repeat (LATENCY + 2) @(posedge clock);
   endtask

   // Write both registers back to back; the block is idle here
   task automatic apply_settings(input logic cs_low, input logic [7:0] flen);
      csr_write_enable <= 1'b1;
      csr_index        <= CSR_CS_ACTIVE_LOW;
      csr_write_data   <= CSR_DATA_W'(cs_low);
      @(posedge clock);
      csr_index        <= CSR_FRAME_LENGTH;
      csr_write_data   <= flen;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      @(posedge clock);
      setting_count++;
   endtask

   // One phase of random traffic under one register setting.
   // Most of it is well-formed frames: a run of pushes (the first one often arming
   // capture), as many transfer-done events, then a few pops. The rest is single
   // transactions drawn from every action, unused codes included.
   task automatic run_phase(input logic cs_low, input logic [7:0] flen, input int n_items,
                            input int max_frame, input int max_pops, input bit idle_on,
                            input bit squeeze, input bit pause_mid);
      int  counted;
      int  n;
      int  i;
      int  pick;
      bit  paused;
      wait_quiet();
      apply_settings(cs_low, flen);
      recv_idle_on = idle_on;
      counted      = 0;
      paused       = 1'b0;
      if (squeeze) begin
         // hold the receiver off and flood the input until the block pushes back
         stall_req    = 1'b1;
         send_idle_on = 1'b0;
         for (i = 0; i < SQUEEZE_TXNS; i++)
            send_txn($urandom_range(0, 1) ? ACT_PUSH : ACT_DONE, rand_byte());
         counted += SQUEEZE_TXNS;
      end
      while (counted < n_items) begin
         if (pause_mid && !paused && counted >= n_items / 2) begin
            wait_quiet();
            paused = 1'b1;
         end
         // leave some frames free of sender gaps even in an idling phase
         send_idle_on = idle_on && ($urandom_range(0, 3) != 0);
         if ($urandom_range(0, 9) < 6) begin
            n = $urandom_range(1, max_frame);
            for (i = 0; i < n; i++)
               send_txn((i == 0 && $urandom_range(0, 1)) ? ACT_PUSH_ARM : ACT_PUSH, rand_byte());
            for (i = 0; i < n; i++)
               send_txn(ACT_DONE, rand_byte());
            counted += 2 * n;
            n = $urandom_range(0, max_pops);
            for (i = 0; i < n; i++)
               send_txn(ACT_POP, rand_byte());
            counted += n;
         end else begin
            pick = $urandom_range(0, 99);
            if      (pick < 22) send_txn(ACT_PUSH, rand_byte());
            else if (pick < 36) send_txn(ACT_PUSH_ARM, rand_byte());
            else if (pick < 64) send_txn(ACT_DONE, rand_byte());
            else if (pick < 84) send_txn(ACT_POP, rand_byte());
            else if (pick < 92) send_txn(ACT_CLEAR, rand_byte());
            else send_txn(ACT_W'($urandom_range(ACT_SPARE_LO, ACT_SPARE_HI)), rand_byte());
            // ignored codes do not count towards the phase
            if (pick < 92) counted++;
         end
      end
   endtask

   // Receiver: draw a gap per result, and honour a long hold-off when asked
   initial begin
      int gap;
      rsp_if.ready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if (stall_req) begin
            rsp_if.ready <= 1'b0;
            repeat (STALL_CYCLES) @(posedge clock);
            stall_req = 1'b0;
         end
         gap = draw_gap(recv_idle_on);
         if (gap > 0) begin
            rsp_if.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_if.ready <= 1'b1;
         do @(posedge clock); while (!rsp_if.valid);
      end
   end

   // Stimulus and verdict
   initial begin
      txn_count     = 0;
      setting_count = 0;
      send_idle_on  = 1'b1;
      recv_idle_on  = 1'b1;
      stall_req     = 1'b0;
      req_if.valid     <= 1'b0;
      req_if.action    <= ACT_PUSH;
      req_if.data      <= '0;
      csr_write_enable <= 1'b0;
      csr_index        <= CSR_CS_ACTIVE_LOW;
      csr_write_data   <= '0;
      reset            <= 1'b1;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part, under the reset settings (chip select active high, one-byte frames)
      send_txn(ACT_DONE, 8'h5A);        // transfer done while idle: frame check only
      send_txn(ACT_POP, 8'h00);         // pop from an empty receive ring
      send_txn(ACT_PUSH, 8'h00);        // push into an idle ring starts the byte at once
      send_txn(ACT_PUSH_ARM, 8'hFF);    // queue behind it and arm capture
      send_txn(ACT_DONE, 8'hFF);        // capture, end the frame, disarm, start next byte
      send_txn(ACT_DONE, 8'h00);        // no longer armed: byte not stored
      send_txn(ACT_POP, 8'h00);         // drain the captured byte
      send_txn(ACT_SPARE_LO, 8'hAA);    // unused codes are ignored
      send_txn(ACT_SPARE_HI, 8'h55);
      send_txn(ACT_PUSH_ARM, 8'h81);
      send_txn(ACT_DONE, 8'h7E);
      send_txn(ACT_CLEAR, 8'h00);       // clear a non-empty receive ring

      // Random phases, one register setting each:
      // long frames with few pops overrun the receive ring and hit the clear-on-capture case
      run_phase(1'b1, 8'd255, 70, 20, 1, 1'b1, 1'b0, 1'b0);
      // frames longer than the transmit ring: refused pushes, arming on a refused push
      run_phase(1'b0, 8'd1, 70, 20, 2, 1'b1, 1'b0, 1'b0);
      // no idling on either side
      run_phase(1'b1, 8'd3, 60, 8, 4, 1'b0, 1'b0, 1'b0);
      // a frame length of zero only ends a frame once the count wraps
      run_phase(1'b0, 8'd0, 50, 12, 3, 1'b1, 1'b0, 1'b0);
      // receiver holds off while the sender floods the input
      run_phase(1'b1, 8'd2, 100, 10, 4, 1'b1, 1'b1, 1'b0);
      // random frame length; sender pauses halfway until all results are back
      run_phase(1'b0, 8'($urandom_range(1, 255)), 90, 16, 6, 1'b1, 1'b0, 1'b1);

      wait_quiet();
      repeat (LATENCY * 4) @(posedge clock);

      $display("Covered %0d transactions over %0d register settings; %0d results checked.",
               txn_count, setting_count + 1, checked_count);
      $display("Saw %0d refused pushes and %0d receive ring clears on overrun.",
               refused_count, overrun_clears);
      if (fail_count == 0 && pending_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule

[files.f]
+incdir+design
design/smcf_pkg.sv
design/smcf_channel_if.sv
design/spi_master_fifo_cs_framer_unit.sv
sim/spi_master_fifo_cs_framer_checker.sv
sim/spi_master_fifo_cs_framer_unit_test.sv
